// File: hw/rtl/wwc_pkg.sv
// ----------------------------------------------------------------------------
// Weighted word count package
// Shared constants, codes, control structs and helper functions for the
// weighted word count block with its ranked list.
// ----------------------------------------------------------------------------
package wwc_pkg;

  // Sizes of the two cell chains.
  localparam int MAX_QUERY_BYTES = 8;
  localparam int MAX_TOP         = 8;

  // Fixed field widths.
  localparam int BYTE_W    = 8;
  localparam int ID_W      = 16;
  localparam int SCORE_W   = 16;
  localparam int KIND_W    = 2;
  localparam int SEL_W     = 2;
  localparam int QWORD_W   = 64;
  localparam int LEN_W     = 4;
  localparam int TOP_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int WEIGHT_W  = 2;

  // Derived widths.
  localparam int QIDX_W  = (MAX_QUERY_BYTES > 1) ? $clog2(MAX_QUERY_BYTES) : 1;
  localparam int SKIP_W  = QIDX_W;
  localparam int TOP_N_W = $clog2(MAX_TOP + 1);

  // Word kinds on the input channel.
  typedef enum logic [KIND_W-1:0] {
    KIND_TEXT   = 2'd0,
    KIND_END    = 2'd1,
    KIND_REPORT = 2'd2
  } kind_t;

  // Field selector codes and their weights.
  localparam logic [SEL_W-1:0]    FIELD_TITLE  = 2'd0;
  localparam logic [SEL_W-1:0]    FIELD_TAGS   = 2'd1;
  localparam logic [SEL_W-1:0]    FIELD_PLOT   = 2'd2;
  localparam logic [WEIGHT_W-1:0] WEIGHT_TITLE = 2'd3;
  localparam logic [WEIGHT_W-1:0] WEIGHT_TAGS  = 2'd2;
  localparam logic [WEIGHT_W-1:0] WEIGHT_PLOT  = 2'd1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_NONE  = 2'd0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_WORD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_COUNT  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [LEN_W-1:0] QUERY_LEN_RST = 4'd1;
  localparam logic [TOP_W-1:0] TOP_COUNT_RST = 4'd5;

  // Control of one match cell.
  typedef struct packed {
    logic shift;
    logic start;
    logic flush;
  } mcell_ctl_t;

  // Control of one rank cell.
  typedef struct packed {
    logic insert;
    logic pop;
  } rcell_ctl_t;

  // Query length clipped to the window size.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (int'(v) > MAX_QUERY_BYTES) begin
      r = LEN_W'(MAX_QUERY_BYTES);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // List length clipped to one and to the chain length.
  function automatic logic [TOP_N_W-1:0] eff_top(input logic [TOP_W-1:0] v);
    logic [TOP_N_W-1:0] r;
    if (v == '0) begin
      r = TOP_N_W'(1);
    end else if (int'(v) > MAX_TOP) begin
      r = TOP_N_W'(MAX_TOP);
    end else begin
      r = TOP_N_W'(v);
    end
    return r;
  endfunction

  // Score weight of a field.
  function automatic logic [WEIGHT_W-1:0] field_weight(input logic [SEL_W-1:0] sel);
    logic [WEIGHT_W-1:0] w;
    unique case (sel)
      FIELD_TITLE: w = WEIGHT_TITLE;
      FIELD_TAGS:  w = WEIGHT_TAGS;
      FIELD_PLOT:  w = WEIGHT_PLOT;
      default:     w = WEIGHT_NONE;
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/wwc_if.sv
// ----------------------------------------------------------------------------
// Weighted word count channels
// Valid/ready channels for text words, ranked results and register writes.
// ----------------------------------------------------------------------------

// Input channel: one text byte, end of record or report word per handshake.
interface wwc_in_if;
  logic                          valid;
  logic                          ready;
  logic [wwc_pkg::KIND_W-1:0]    kind;
  logic [wwc_pkg::SEL_W-1:0]     field_sel;
  logic                          field_start;
  logic [wwc_pkg::BYTE_W-1:0]    text_byte;
  logic [wwc_pkg::ID_W-1:0]      record_id;

  modport source (output valid, kind, field_sel, field_start, text_byte, record_id,
                  input ready);
  modport sink   (input valid, kind, field_sel, field_start, text_byte, record_id,
                  output ready);
endinterface

// Result channel: one ranked entry per handshake.
interface wwc_out_if;
  logic                          valid;
  logic                          ready;
  logic [wwc_pkg::ID_W-1:0]      out_record_id;
  logic [wwc_pkg::SCORE_W-1:0]   out_score;
  logic                          last;

  modport source (output valid, out_record_id, out_score, last, input ready);
  modport sink   (input valid, out_record_id, out_score, last, output ready);
endinterface

// Configuration write channel.
interface wwc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [wwc_pkg::CFG_IDX_W-1:0]   index;
  logic [wwc_pkg::QWORD_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/wwc_match_cell.sv
// ----------------------------------------------------------------------------
// Match cell
// Holds one byte of the match window and compares the byte that it will hold
// after the shift with its query byte.
// ----------------------------------------------------------------------------
module wwc_match_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wwc_pkg::mcell_ctl_t         ctl,
  input  logic [wwc_pkg::BYTE_W-1:0]  byte_in,
  input  logic                        valid_in,
  input  logic [wwc_pkg::BYTE_W-1:0]  q_byte,
  input  logic                        active,
  output logic [wwc_pkg::BYTE_W-1:0]  byte_o,
  output logic                        valid_o,
  output logic                        hit_o
);

  logic [wwc_pkg::BYTE_W-1:0] byte_r;
  logic [wwc_pkg::BYTE_W-1:0] byte_nxt;
  logic                       valid_r;
  logic                       valid_nxt;

  // A field start empties the window before the new byte comes in.
  always_comb begin
    byte_nxt  = byte_in;
    valid_nxt = ctl.start ? 1'b0 : valid_in;
  end

  // Cells beyond the query length always agree.
  assign hit_o   = !active || (valid_nxt && (byte_nxt == q_byte));
  assign byte_o  = byte_r;
  assign valid_o = valid_r;

  // Valid bit of the window position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.flush) begin
      valid_r <= 1'b0;
    end else if (ctl.shift) begin
      valid_r <= valid_nxt;
    end
  end

  // Window byte.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      byte_r <= byte_nxt;
    end
  end

endmodule

// File: hw/rtl/wwc_rank_cell.sv
// ----------------------------------------------------------------------------
// Rank cell
// Holds one entry of the descending ranked list. On an insert it keeps its
// entry, takes the new one or takes its upper neighbour's, or drops it when
// outside the list length; on a pop it takes its lower neighbour's entry.
// ----------------------------------------------------------------------------
module wwc_rank_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  wwc_pkg::rcell_ctl_t          ctl,
  input  logic                         in_range,
  input  logic [wwc_pkg::ID_W-1:0]     new_id,
  input  logic [wwc_pkg::SCORE_W-1:0]  new_score,
  input  logic [wwc_pkg::ID_W-1:0]     prev_id,
  input  logic [wwc_pkg::SCORE_W-1:0]  prev_score,
  input  logic                         prev_ev,
  input  logic                         prev_ge,
  input  logic [wwc_pkg::ID_W-1:0]     next_id,
  input  logic [wwc_pkg::SCORE_W-1:0]  next_score,
  input  logic                         next_ev,
  output logic [wwc_pkg::ID_W-1:0]     id_o,
  output logic [wwc_pkg::SCORE_W-1:0]  score_o,
  output logic                         ev_o,
  output logic                         ge_o
);

  logic [wwc_pkg::ID_W-1:0]    id_r;
  logic [wwc_pkg::ID_W-1:0]    id_nxt;
  logic [wwc_pkg::SCORE_W-1:0] score_r;
  logic [wwc_pkg::SCORE_W-1:0] score_nxt;
  logic                        valid_r;
  logic                        valid_nxt;
  logic                        ev;
  logic                        ge;

  // An entry counts only inside the current list length; an equal score
  // stays ahead of the newcomer.
  assign ev = valid_r && in_range;
  assign ge = ev && (score_r >= new_score);

  assign id_o    = id_r;
  assign score_o = score_r;
  assign ev_o    = ev;
  assign ge_o    = ge;

  // Insert and pop steps.
  always_comb begin
    id_nxt    = id_r;
    score_nxt = score_r;
    valid_nxt = valid_r;
    priority if (ctl.insert) begin
      if (!in_range) begin
        valid_nxt = 1'b0;
      end else if (!ge) begin
        if (prev_ge) begin
          id_nxt    = new_id;
          score_nxt = new_score;
          valid_nxt = 1'b1;
        end else begin
          id_nxt    = prev_id;
          score_nxt = prev_score;
          valid_nxt = prev_ev;
        end
      end
    end else if (ctl.pop) begin
      id_nxt    = next_id;
      score_nxt = next_score;
      valid_nxt = next_ev;
    end
  end

  // Entry valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Entry payload.
  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    score_r <= score_nxt;
  end

endmodule

// File: hw/rtl/weighted_word_count_top_k_top.sv
// ----------------------------------------------------------------------------
// Weighted word count with ranked top-N list
// The block takes one word per cycle on its input channel while no report
// is draining. Text bytes pass through a chain of eight match cells that
// hold the query window, and each leftmost, non-overlapping match of the
// query adds the field's weight to the record's saturating score. An
// end-of-record word inserts the record into a chain of rank cells, each
// cell deciding from its own entry and its neighbour's. Text and
// end-of-record words therefore go at one per cycle outside a drain. A
// report word stalls the input while the rank chain shifts its entries
// out, one per cycle while the result channel is ready, through an output
// register. Register writes are always ready; the user must make them only
// while the block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module weighted_word_count_top_k_top (
  input  logic          clk,
  input  logic          rst_n,
  wwc_in_if.sink        in_ch,
  wwc_out_if.source     out_ch,
  wwc_cfg_if.sink       cfg_ch
);

  localparam int MQ = wwc_pkg::MAX_QUERY_BYTES;
  localparam int MT = wwc_pkg::MAX_TOP;

  // Configuration registers.
  logic [wwc_pkg::QWORD_W-1:0] qword_r;
  logic [wwc_pkg::LEN_W-1:0]   qlen_r;
  logic [wwc_pkg::TOP_W-1:0]   topc_r;

  // Scoring state.
  logic [wwc_pkg::SKIP_W-1:0]  skip_r;
  logic [wwc_pkg::SKIP_W-1:0]  skip_nxt;
  logic [wwc_pkg::SCORE_W-1:0] score_r;
  logic [wwc_pkg::SCORE_W-1:0] score_nxt;

  // Report drain and output register.
  logic                        drain_r;
  logic                        drain_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic [wwc_pkg::ID_W-1:0]    out_id_r;
  logic [wwc_pkg::SCORE_W-1:0] out_score_r;
  logic                        out_last_r;

  // Handshake decodes.
  logic                        in_acc;
  logic                        take_byte;
  logic                        take_end;
  logic                        take_report;
  logic                        load_out;
  logic                        last_entry;

  logic [wwc_pkg::LEN_W-1:0]   len_eff;
  logic [wwc_pkg::TOP_N_W-1:0] top_n;
  logic                        match;

  // Match chain wiring.
  logic [wwc_pkg::BYTE_W-1:0]  mbyte [MQ];
  logic                        mvalid [MQ];
  logic [MQ-1:0]               mhit;

  // Rank chain wiring.
  logic [wwc_pkg::ID_W-1:0]    rid [MT];
  logic [wwc_pkg::SCORE_W-1:0] rscore [MT];
  logic [MT-1:0]               rev;
  logic [MT-1:0]               rge;
  logic [MT-1:0]               nev;
  wwc_pkg::rcell_ctl_t         rctl;

  assign len_eff = wwc_pkg::eff_len(qlen_r);
  assign top_n   = wwc_pkg::eff_top(topc_r);

  assign in_ch.ready  = !drain_r;
  assign cfg_ch.ready = 1'b1;

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign take_byte   = in_acc && (in_ch.kind == wwc_pkg::KIND_TEXT);
  assign take_end    = in_acc && (in_ch.kind == wwc_pkg::KIND_END);
  assign take_report = in_acc && (in_ch.kind == wwc_pkg::KIND_REPORT);

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qword_r <= '0;
      qlen_r  <= wwc_pkg::QUERY_LEN_RST;
      topc_r  <= wwc_pkg::TOP_COUNT_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        wwc_pkg::REG_QUERY_WORD: qword_r <= cfg_ch.data;
        wwc_pkg::REG_QUERY_LEN:  qlen_r  <= cfg_ch.data[wwc_pkg::LEN_W-1:0];
        wwc_pkg::REG_TOP_COUNT:  topc_r  <= cfg_ch.data[wwc_pkg::TOP_W-1:0];
        default: ;
      endcase
    end
  end

  // Match chain: cell j holds the byte j positions back and compares it
  // with query byte (length - 1 - j).
  for (genvar j = 0; j < MQ; j++) begin : g_match
    wwc_pkg::mcell_ctl_t        mctl;
    logic [wwc_pkg::QIDX_W-1:0] q_idx;
    logic [wwc_pkg::BYTE_W-1:0] q_byte;
    logic [wwc_pkg::BYTE_W-1:0] byte_in;
    logic                       valid_in;
    logic                       active;

    assign active = (wwc_pkg::LEN_W'(j) < len_eff);
    assign q_idx  = wwc_pkg::QIDX_W'(len_eff - wwc_pkg::LEN_W'(j + 1));
    assign q_byte = qword_r[wwc_pkg::BYTE_W*q_idx +: wwc_pkg::BYTE_W];

    assign mctl.shift = take_byte;
    assign mctl.flush = take_end;

    if (j == 0) begin : g_head
      assign byte_in    = in_ch.text_byte;
      assign valid_in   = 1'b1;
      assign mctl.start = 1'b0;
    end else begin : g_body
      assign byte_in    = mbyte[j-1];
      assign valid_in   = mvalid[j-1];
      assign mctl.start = in_ch.field_start;
    end

    wwc_match_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (mctl),
      .byte_in  (byte_in),
      .valid_in (valid_in),
      .q_byte   (q_byte),
      .active   (active),
      .byte_o   (mbyte[j]),
      .valid_o  (mvalid[j]),
      .hit_o    (mhit[j])
    );
  end

  assign match = (len_eff != '0) && (&mhit);

  // Skip count and saturating score.
  always_comb begin
    logic [wwc_pkg::SKIP_W-1:0]  skip_cur;
    logic [wwc_pkg::SCORE_W:0]   sum;
    skip_cur  = in_ch.field_start ? '0 : skip_r;
    sum       = {1'b0, score_r}
              + (wwc_pkg::SCORE_W+1)'(wwc_pkg::field_weight(in_ch.field_sel));
    skip_nxt  = skip_r;
    score_nxt = score_r;
    priority if (take_end) begin
      skip_nxt  = '0;
      score_nxt = '0;
    end else if (take_byte) begin
      if (skip_cur != '0) begin
        skip_nxt = skip_cur - wwc_pkg::SKIP_W'(1);
      end else if (match) begin
        skip_nxt  = wwc_pkg::SKIP_W'(len_eff - wwc_pkg::LEN_W'(1));
        score_nxt = sum[wwc_pkg::SCORE_W] ? '1 : sum[wwc_pkg::SCORE_W-1:0];
      end else begin
        skip_nxt = skip_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r  <= '0;
      score_r <= '0;
    end else begin
      skip_r  <= skip_nxt;
      score_r <= score_nxt;
    end
  end

  // Rank chain.
  assign rctl.insert = take_end;
  assign rctl.pop    = load_out;

  for (genvar k = 0; k < MT; k++) begin : g_rank
    logic [wwc_pkg::ID_W-1:0]    prev_id;
    logic [wwc_pkg::SCORE_W-1:0] prev_score;
    logic                        prev_ev;
    logic                        prev_ge;
    logic [wwc_pkg::ID_W-1:0]    next_id;
    logic [wwc_pkg::SCORE_W-1:0] next_score;
    logic                        in_range;

    assign in_range = (wwc_pkg::TOP_N_W'(k) < top_n);

    if (k == 0) begin : g_first
      assign prev_id    = '0;
      assign prev_score = '0;
      assign prev_ev    = 1'b0;
      assign prev_ge    = 1'b1;
    end else begin : g_upper
      assign prev_id    = rid[k-1];
      assign prev_score = rscore[k-1];
      assign prev_ev    = rev[k-1];
      assign prev_ge    = rge[k-1];
    end

    if (k == MT - 1) begin : g_last
      assign next_id    = '0;
      assign next_score = '0;
      assign nev[k]     = 1'b0;
    end else begin : g_lower
      assign next_id    = rid[k+1];
      assign next_score = rscore[k+1];
      assign nev[k]     = rev[k+1];
    end

    wwc_rank_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (rctl),
      .in_range   (in_range),
      .new_id     (in_ch.record_id),
      .new_score  (score_r),
      .prev_id    (prev_id),
      .prev_score (prev_score),
      .prev_ev    (prev_ev),
      .prev_ge    (prev_ge),
      .next_id    (next_id),
      .next_score (next_score),
      .next_ev    (nev[k]),
      .id_o       (rid[k]),
      .score_o    (rscore[k]),
      .ev_o       (rev[k]),
      .ge_o       (rge[k])
    );
  end

  // Report drain: pop the head entry into the output register whenever it
  // is free; finish when the list runs empty.
  assign load_out   = drain_r && rev[0] && (!out_valid_r || out_ch.ready);
  assign last_entry = !nev[0];

  always_comb begin
    drain_nxt = drain_r;
    priority if (take_report) begin
      drain_nxt = 1'b1;
    end else if (drain_r && (!rev[0] || (load_out && last_entry))) begin
      drain_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_id_r    <= rid[0];
      out_score_r <= rscore[0];
      out_last_r  <= last_entry;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_record_id = out_id_r;
  assign out_ch.out_score     = out_score_r;
  assign out_ch.last          = out_last_r;

  // The ranked entries always form an unbroken run from the head.
  ap_rank_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((rev >> 1) & ~rev) == '0)
    else $error("Ranked list has a gap.");

  // A report word stops the input on the following cycle.
  ap_report_stall: assert property (@(posedge clk) disable iff (!rst_n)
    take_report |=> !in_ch.ready)
    else $error("Input not stalled after a report word.");

  // Popping the final entry leaves the list empty.
  ap_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && last_entry) |=> !rev[0])
    else $error("List not empty after the final entry.");

endmodule

// File: tb/wwc_rank_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ranked list checker for the weighted word count block
// Watches the register, input and result channels. It keeps its own copy of
// the configuration, the match window, the record score and the ranked list,
// works out the entries that each accepted report word must produce, and
// compares every accepted result word with the oldest entry still owed.
// ----------------------------------------------------------------------------
module wwc_rank_checker (
  input  logic clk,
  input  logic rst_n,
  wwc_in_if    in_ch,
  wwc_out_if   out_ch,
  wwc_cfg_if   cfg_ch,
  output int   mismatch_count,
  output int   entries_owed
);

  localparam int SCORE_MAX = (1 << wwc_pkg::SCORE_W) - 1;

  typedef struct packed {
    logic [wwc_pkg::ID_W-1:0]    id;
    logic [wwc_pkg::SCORE_W-1:0] score;
    logic                        last;
  } rank_entry_t;

  // Shadow configuration.
  logic [wwc_pkg::QWORD_W-1:0] query_bytes;
  logic [wwc_pkg::LEN_W-1:0]   query_len;
  logic [wwc_pkg::TOP_W-1:0]   keep_count;

  // Shadow matching state of the current record.
  logic [wwc_pkg::QWORD_W-1:0] recent_bytes;
  int                          recent_fill;
  int                          covered_left;
  logic [wwc_pkg::SCORE_W-1:0] record_score;

  // Shadow ranked list, best score first.
  logic [wwc_pkg::ID_W-1:0]    list_id    [wwc_pkg::MAX_TOP];
  logic [wwc_pkg::SCORE_W-1:0] list_score [wwc_pkg::MAX_TOP];
  int                          list_len;

  rank_entry_t owed_q[$];
  int          fails = 0;

  // Number of entries the list may hold under the current setting.
  function automatic int list_limit();
    int n;
    if (keep_count == '0) begin
      n = 1;
    end else if (int'(keep_count) > wwc_pkg::MAX_TOP) begin
      n = wwc_pkg::MAX_TOP;
    end else begin
      n = int'(keep_count);
    end
    return n;
  endfunction

  function automatic void clear_match_window();
    recent_bytes = '0;
    recent_fill  = 0;
    covered_left = 0;
  endfunction

  // One text byte: shift it into the window and score a leftmost,
  // non-overlapping match ending here.
  function automatic void absorb_text(input logic [wwc_pkg::SEL_W-1:0] sel,
                                      input logic start,
                                      input logic [wwc_pkg::BYTE_W-1:0] b);
    int len;
    int k;
    int gain;
    int sum;
    logic hit;
    len = (int'(query_len) > wwc_pkg::MAX_QUERY_BYTES) ? wwc_pkg::MAX_QUERY_BYTES
                                                       : int'(query_len);
    if (start) begin
      clear_match_window();
    end
    recent_bytes = {recent_bytes[wwc_pkg::QWORD_W-wwc_pkg::BYTE_W-1:0], b};
    if (recent_fill < wwc_pkg::MAX_QUERY_BYTES) begin
      recent_fill++;
    end
    if (covered_left != 0) begin
      covered_left--;
      return;
    end
    if (len == 0 || recent_fill < len) begin
      return;
    end
    hit = 1'b1;
    for (k = 0; k < len; k++) begin
      if (query_bytes[wwc_pkg::BYTE_W*k +: wwc_pkg::BYTE_W] !=
          recent_bytes[wwc_pkg::BYTE_W*(len-1-k) +: wwc_pkg::BYTE_W]) begin
        hit = 1'b0;
      end
    end
    if (!hit) begin
      return;
    end
    covered_left = len - 1;
    case (sel)
      wwc_pkg::FIELD_TITLE: gain = int'(wwc_pkg::WEIGHT_TITLE);
      wwc_pkg::FIELD_TAGS:  gain = int'(wwc_pkg::WEIGHT_TAGS);
      wwc_pkg::FIELD_PLOT:  gain = int'(wwc_pkg::WEIGHT_PLOT);
      default:              gain = int'(wwc_pkg::WEIGHT_NONE);
    endcase
    sum = int'(record_score) + gain;
    record_score = (sum > SCORE_MAX) ? wwc_pkg::SCORE_W'(SCORE_MAX)
                                     : wwc_pkg::SCORE_W'(sum);
  endfunction

  // Sorted insert; an equal score goes behind the entries already held.
  function automatic void rank_record(input logic [wwc_pkg::ID_W-1:0] id,
                                      input logic [wwc_pkg::SCORE_W-1:0] score);
    int n;
    int p;
    int i;
    n = list_limit();
    if (list_len > n) begin
      list_len = n;
    end
    p = 0;
    while (p < list_len && list_score[p] >= score) begin
      p++;
    end
    if (p < n) begin
      if (list_len < n) begin
        list_len++;
      end
      for (i = list_len - 1; i > p; i--) begin
        list_id[i]    = list_id[i-1];
        list_score[i] = list_score[i-1];
      end
      list_id[p]    = id;
      list_score[p] = score;
    end
  endfunction

  // A report owes the whole list, best first, and then empties it.
  function automatic void emit_ranking();
    int i;
    rank_entry_t e;
    if (list_len > list_limit()) begin
      list_len = list_limit();
    end
    for (i = 0; i < list_len; i++) begin
      e.id    = list_id[i];
      e.score = list_score[i];
      e.last  = (i == list_len - 1);
      owed_q.insert(owed_q.size(), e);
    end
    list_len = 0;
  endfunction

  always @(posedge clk) begin
    rank_entry_t seen;
    rank_entry_t want;
    if (!rst_n) begin
      query_bytes  = '0;
      query_len    = wwc_pkg::QUERY_LEN_RST;
      keep_count   = wwc_pkg::TOP_COUNT_RST;
      clear_match_window();
      record_score = '0;
      list_len     = 0;
      owed_q.delete();
    end else begin
      // Register writes come first; they only happen while the block is idle.
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          wwc_pkg::REG_QUERY_WORD: query_bytes = cfg_ch.data;
          wwc_pkg::REG_QUERY_LEN:  query_len   = cfg_ch.data[wwc_pkg::LEN_W-1:0];
          wwc_pkg::REG_TOP_COUNT:  keep_count  = cfg_ch.data[wwc_pkg::TOP_W-1:0];
          default: ;
        endcase
      end

      // Predict from every accepted input word.
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.kind)
          wwc_pkg::KIND_TEXT: begin
            absorb_text(in_ch.field_sel, in_ch.field_start, in_ch.text_byte);
          end
          wwc_pkg::KIND_END: begin
            rank_record(in_ch.record_id, record_score);
            record_score = '0;
            clear_match_window();
          end
          wwc_pkg::KIND_REPORT: begin
            emit_ranking();
          end
          default: ;
        endcase
      end

      // Compare each accepted result word with the oldest owed entry.
      if (out_ch.valid && out_ch.ready) begin
        seen.id    = out_ch.out_record_id;
        seen.score = out_ch.out_score;
        seen.last  = out_ch.last;
        if (owed_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result word, expected none, actual id %h score %0d last %b",
                   $time, seen.id, seen.score, seen.last);
        end else begin
          want = owed_q.pop_front();
          if (seen.id != want.id) begin
            fails++;
            $display("%0t: record id mismatch, expected %h actual %h",
                     $time, want.id, seen.id);
          end
          if (seen.score != want.score) begin
            fails++;
            $display("%0t: score mismatch for id %h, expected %0d actual %0d",
                     $time, want.id, want.score, seen.score);
          end
          if (seen.last != want.last) begin
            fails++;
            $display("%0t: last flag mismatch for id %h, expected %b actual %b",
                     $time, want.id, want.last, seen.last);
          end
        end
      end
    end
    mismatch_count <= fails;
    entries_owed   <= owed_q.size();
  end

endmodule

// File: tb/weighted_word_count_top_k_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the weighted word count block with its ranked list
// Drives a short directed sequence and phases of random records under
// several query and list settings, with the sender and receiver idling at
// different rates. The rank checker beside the block predicts and compares
// every result word; this module gives the verdict.
// ----------------------------------------------------------------------------
module weighted_word_count_top_k_top_tb;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 3;
  localparam int SETTLE_CYCLES = 12;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_WORDS   = 20;
  localparam int PHASES        = 8;
  localparam int MIN_RESULTS   = 48;
  localparam int EXTRA_WORDS   = 24;

  // Codes that the block does not define.
  localparam logic [wwc_pkg::KIND_W-1:0] KIND_UNUSED  = 2'd3;
  localparam logic [wwc_pkg::SEL_W-1:0]  FIELD_UNUSED = 2'd3;
  localparam logic [wwc_pkg::BYTE_W-1:0] FILL_CHAR    = 8'h61;

  logic clk = 1'b0;
  logic rst_n;

  wwc_in_if  in_ch ();
  wwc_out_if out_ch ();
  wwc_cfg_if cfg_ch ();

  int mismatch_count;
  int entries_owed;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int words_sent   = 0;
  int entries_seen = 0;
  int quiet_cycles = 0;

  // Current query, kept to shape the text towards matches.
  logic [wwc_pkg::QWORD_W-1:0] cur_word = '0;
  logic [wwc_pkg::LEN_W-1:0]   cur_len  = wwc_pkg::QUERY_LEN_RST;

  always #CLK_HALF clk = ~clk;

  weighted_word_count_top_k_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  wwc_rank_checker rank_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_ch         (cfg_ch),
    .mismatch_count (mismatch_count),
    .entries_owed   (entries_owed)
  );

  // Receiver: ready drops at random according to the current stall rate.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on cycles in which no channel moves a word.
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) begin
      entries_seen <= entries_seen + 1;
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one word on the input channel, after random idle cycles.
  task automatic put_word(input logic [wwc_pkg::KIND_W-1:0] k,
                          input logic [wwc_pkg::SEL_W-1:0] sel,
                          input logic st, input logic [wwc_pkg::BYTE_W-1:0] b,
                          input logic [wwc_pkg::ID_W-1:0] id);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= k;
    in_ch.field_sel   <= sel;
    in_ch.field_start <= st;
    in_ch.text_byte   <= b;
    in_ch.record_id   <= id;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    if (k != KIND_UNUSED) begin
      words_sent++;
    end
  endtask

  task automatic put_text(input logic [wwc_pkg::SEL_W-1:0] sel, input logic st,
                          input logic [wwc_pkg::BYTE_W-1:0] b);
    put_word(wwc_pkg::KIND_TEXT, sel, st, b, wwc_pkg::ID_W'($urandom));
  endtask

  task automatic put_end(input logic [wwc_pkg::ID_W-1:0] id);
    put_word(wwc_pkg::KIND_END, wwc_pkg::SEL_W'($urandom), 1'($urandom),
             wwc_pkg::BYTE_W'($urandom), id);
  endtask

  task automatic put_report();
    put_word(wwc_pkg::KIND_REPORT, wwc_pkg::SEL_W'($urandom), 1'($urandom),
             wwc_pkg::BYTE_W'($urandom), wwc_pkg::ID_W'($urandom));
  endtask

  // Hold the sender back until every owed entry has come and the block is quiet.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (entries_owed != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers back to back once the block is idle.
  task automatic set_config(input logic [wwc_pkg::QWORD_W-1:0] word,
                            input logic [wwc_pkg::LEN_W-1:0] len,
                            input logic [wwc_pkg::TOP_W-1:0] keep);
    logic [wwc_pkg::CFG_IDX_W-1:0] idx [3];
    logic [wwc_pkg::QWORD_W-1:0]   val [3];
    int r;
    idx[0] = wwc_pkg::REG_QUERY_WORD;
    idx[1] = wwc_pkg::REG_QUERY_LEN;
    idx[2] = wwc_pkg::REG_TOP_COUNT;
    val[0] = word;
    val[1] = wwc_pkg::QWORD_W'(len);
    val[2] = wwc_pkg::QWORD_W'(keep);
    wait_drained();
    for (r = 0; r < 3; r++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[r];
      cfg_ch.data  <= val[r];
      @(posedge clk);
      while (!cfg_ch.ready) begin
        @(posedge clk);
      end
    end
    cfg_ch.valid <= 1'b0;
    cur_word = word;
    cur_len  = len;
  endtask

  // One record: a few fields rich in query bytes, with some noise, and
  // now and then a missing end word.
  task automatic random_record();
    int eff;
    int fields;
    int f;
    int flen;
    int n;
    int j;
    logic [wwc_pkg::SEL_W-1:0]  sel;
    logic [wwc_pkg::BYTE_W-1:0] b;
    logic                       first;
    eff = (int'(cur_len) > wwc_pkg::MAX_QUERY_BYTES) ? wwc_pkg::MAX_QUERY_BYTES
                                                     : int'(cur_len);
    fields = $urandom_range(0, 3);
    for (f = 0; f < fields; f++) begin
      sel   = ($urandom_range(9) == 0) ? FIELD_UNUSED
                                       : wwc_pkg::SEL_W'($urandom_range(2));
      flen  = $urandom_range(1, 12);
      n     = 0;
      first = 1'b1;
      while (n < flen) begin
        if (eff > 0 && $urandom_range(1) == 0) begin
          // The whole query, so that matches and overlaps are common.
          for (j = 0; j < eff; j++) begin
            put_text(sel, first | ($urandom_range(19) == 0),
                     cur_word[wwc_pkg::BYTE_W*j +: wwc_pkg::BYTE_W]);
            first = 1'b0;
            n++;
          end
        end else begin
          j = $urandom_range((eff > 0) ? eff - 1 : 0);
          b = ($urandom_range(2) == 0) ? wwc_pkg::BYTE_W'($urandom)
                                       : cur_word[wwc_pkg::BYTE_W*j +: wwc_pkg::BYTE_W];
          put_text(sel, first | ($urandom_range(19) == 0), b);
          first = 1'b0;
          n++;
        end
      end
    end
    if ($urandom_range(11) != 0) begin
      put_end(wwc_pkg::ID_W'($urandom));
    end
  endtask

  initial begin
    int ph;
    int j;
    int target;
    logic [wwc_pkg::QWORD_W-1:0] w;
    logic [wwc_pkg::LEN_W-1:0]   len;
    logic [wwc_pkg::TOP_W-1:0]   keep;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= wwc_pkg::KIND_TEXT;
    in_ch.field_sel   <= wwc_pkg::FIELD_TITLE;
    in_ch.field_start <= 1'b0;
    in_ch.text_byte   <= '0;
    in_ch.record_id   <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= wwc_pkg::REG_QUERY_WORD;
    cfg_ch.data       <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: a report on the empty list, an unknown kind, a zero
    // byte matching in every field, and two records with extreme ids.
    put_report();
    put_word(KIND_UNUSED, wwc_pkg::SEL_W'($urandom), 1'($urandom),
             wwc_pkg::BYTE_W'($urandom), wwc_pkg::ID_W'($urandom));
    put_text(wwc_pkg::FIELD_TITLE, 1'b1, 8'h00);
    put_text(wwc_pkg::FIELD_TAGS, 1'b1, 8'h00);
    put_text(wwc_pkg::FIELD_PLOT, 1'b1, 8'h00);
    put_text(FIELD_UNUSED, 1'b1, 8'h00);
    put_end(16'hFFFF);
    put_end(16'h0000);

    // Query of all ones with an oversized length, and a list count of zero:
    // the list is cut to one entry and the weaker record is dropped.
    set_config('1, 4'd15, 4'd0);
    for (j = 0; j < 8; j++) begin
      put_text(wwc_pkg::FIELD_PLOT, (j == 0), 8'hFF);
    end
    put_end(16'h1234);
    put_report();

    // Overlapping occurrences, and a field start breaking a match.
    set_config({48'h0, FILL_CHAR, FILL_CHAR}, 4'd2, 4'd8);
    for (j = 0; j < 4; j++) begin
      put_text(wwc_pkg::FIELD_TITLE, (j == 0), FILL_CHAR);
    end
    put_text(wwc_pkg::FIELD_TAGS, 1'b1, FILL_CHAR);
    put_end(16'h0007);
    put_report();

    // Random phases under different settings and idling.
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  len = 4'd1;  keep = 4'd8;  end
        1: begin idle_pct = 57; stall_pct = 0;  len = 4'd3;  keep = 4'd2;  end
        2: begin idle_pct = 0;  stall_pct = 57; len = 4'd8;  keep = 4'd15; end
        3: begin idle_pct = 20; stall_pct = 20; len = 4'd0;  keep = 4'd0;  end
        4: begin idle_pct = 0;  stall_pct = 0;  len = 4'd12; keep = 4'd5;  end
        5: begin idle_pct = 57; stall_pct = 0;  len = 4'd2;  keep = 4'd1;  end
        6: begin idle_pct = 0;  stall_pct = 57; len = 4'd4;  keep = 4'd8;  end
        default: begin idle_pct = 20; stall_pct = 20; len = 4'd5; keep = 4'd3; end
      endcase
      w = {$urandom, $urandom};
      for (j = 0; j < 8; j++) begin
        if ($urandom_range(1) == 0) begin
          w[wwc_pkg::BYTE_W*j +: wwc_pkg::BYTE_W] = FILL_CHAR;
        end
      end
      set_config(w, len, keep);
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) begin
        random_record();
        if ($urandom_range(2) == 0) begin
          put_report();
          if ($urandom_range(3) == 0) begin
            wait_drained();
          end
        end
        if ($urandom_range(29) == 0) begin
          put_word(KIND_UNUSED, wwc_pkg::SEL_W'($urandom), 1'($urandom),
                   wwc_pkg::BYTE_W'($urandom), wwc_pkg::ID_W'($urandom));
        end
      end
    end

    // Keep going for a short while if few ranked entries have come back.
    target = words_sent + EXTRA_WORDS;
    while (entries_seen < MIN_RESULTS && words_sent < target) begin
      random_record();
      put_report();
    end

    wait_drained();
    if (mismatch_count == 0 && entries_owed == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
